// ===== rtl/core/pwas_pkg.sv =====
package pwas_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF    = 8;
	localparam int COORD_W_DEF  = 16;

	// Tolerance registers and configuration port
	localparam int TOL_W        = 15;
	localparam int TOL_RESET    = 16;
	localparam int CFG_IDX_W    = 1;

	// Q11.4 code stored for a missing point (-1.0)
	localparam int MISSING_CODE = -16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOL_X = 1'b0,
		REG_TOL_Y = 1'b1
	} reg_idx_t;

	// Program counter and step addresses
	localparam int PC_W = 3;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_IDLE     = 3'd0;
	localparam pc_t PC_SCAN     = 3'd1;
	localparam pc_t PC_DRAIN    = 3'd2;
	localparam pc_t PC_DIV_INIT = 3'd3;
	localparam pc_t PC_DIV      = 3'd4;
	localparam pc_t PC_DONE     = 3'd5;

	// Jump conditions
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_ACCEPT,
		C_SCAN_MORE,
		C_DIV_MORE,
		C_OUT_FREE
	} cond_t;

	// One control word: jump when cond is met, else hold or fall through
	typedef struct packed {
		cond_t cond;
		pc_t   target;
		logic  hold;
		logic  op_start;
		logic  op_read;
		logic  op_acc;
		logic  op_div_init;
		logic  op_div_step;
		logic  op_finish;
	} ucode_t;

	// Strobes from sequencer to datapath
	typedef struct packed {
		logic start;
		logic read;
		logic acc;
		logic div_init;
		logic div_step;
		logic finish;
	} ctrl_t;

	// Status from datapath to sequencer
	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic out_free;
	} stat_t;

	// Control store
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		w = '{cond: C_ALWAYS, target: PC_IDLE, hold: 1'b0, op_start: 1'b0, op_read: 1'b0,
			op_acc: 1'b0, op_div_init: 1'b0, op_div_step: 1'b0, op_finish: 1'b0};
		unique case (pc)
			PC_IDLE: begin
				// wait for a word, store it in the window
				w.cond     = C_ACCEPT;
				w.target   = PC_SCAN;
				w.hold     = 1'b1;
				w.op_start = 1'b1;
			end
			PC_SCAN: begin
				// read one held entry a cycle, accumulate the previous one
				w.cond    = C_SCAN_MORE;
				w.target  = PC_SCAN;
				w.op_read = 1'b1;
				w.op_acc  = 1'b1;
			end
			PC_DRAIN: begin
				w.cond   = C_ALWAYS;
				w.target = PC_DIV_INIT;
				w.op_acc = 1'b1;
			end
			PC_DIV_INIT: begin
				w.cond        = C_ALWAYS;
				w.target      = PC_DIV;
				w.op_div_init = 1'b1;
			end
			PC_DIV: begin
				w.cond        = C_DIV_MORE;
				w.target      = PC_DIV;
				w.op_div_step = 1'b1;
			end
			PC_DONE: begin
				w.cond      = C_OUT_FREE;
				w.target    = PC_IDLE;
				w.hold      = 1'b1;
				w.op_finish = 1'b1;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/pwas_sequencer.sv =====
module pwas_sequencer
	import pwas_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output ctrl_t ctrl
);

	pc_t    pc_q;
	ucode_t word;
	logic   cond_met;

	// Fetch the control word
	assign word     = ucode_rom(pc_q);
	assign in_ready = word.op_start;

	// Evaluate the jump condition
	always_comb begin
		unique case (word.cond)
			C_ALWAYS:    cond_met = 1'b1;
			C_ACCEPT:    cond_met = in_valid;
			C_SCAN_MORE: cond_met = !stat.scan_last;
			C_DIV_MORE:  cond_met = !stat.div_last;
			C_OUT_FREE:  cond_met = stat.out_free;
			default:     cond_met = 1'b1;
		endcase
	end

	// Gate the strobes with their wait conditions
	always_comb begin
		ctrl.start    = word.op_start && in_valid;
		ctrl.read     = word.op_read;
		ctrl.acc      = word.op_acc;
		ctrl.div_init = word.op_div_init;
		ctrl.div_step = word.op_div_step;
		ctrl.finish   = word.op_finish && stat.out_free;
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (cond_met) begin
			pc_q <= word.target;
		end else if (!word.hold) begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// ===== rtl/core/pwas_datapath.sv =====
module pwas_datapath
	import pwas_pkg::*;
#(
	parameter int DEPTH   = DEPTH_DEF,
	parameter int COORD_W = COORD_W_DEF,
	localparam int CNT_W  = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_t                     ctrl,
	output stat_t                     stat,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [TOL_W-1:0]          cfg_data,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      point_valid,
	output logic signed [COORD_W-1:0] mean_x,
	output logic signed [COORD_W-1:0] mean_y,
	output logic [CNT_W-1:0]          samples_held,
	output logic                      stable,
	output logic                      out_valid,
	input  logic                      out_ready
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ENT_W  = 2 * COORD_W + 1;
	localparam int SUM_W  = COORD_W + $clog2(DEPTH);
	localparam int REM_W  = CNT_W + 1;
	localparam int DCNT_W = $clog2(SUM_W);
	localparam int CMP_W  = (COORD_W + 1 > TOL_W + 1) ? COORD_W + 1 : TOL_W + 1;

	// Window memory, entry = {valid, x, y}
	logic [ENT_W-1:0] mem_q [DEPTH];
	logic [ENT_W-1:0] rd_data_q;
	logic [ENT_W-1:0] wr_data;

	// Control state
	logic [TOL_W-1:0]  tol_x_q, tol_y_q;
	logic [ADDR_W-1:0] slot_q;
	logic [CNT_W-1:0]  held_q;
	logic [ADDR_W-1:0] idx_q;
	logic              pend_q;
	logic              first_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              out_full_q;

	// Accumulators and divider lanes
	logic signed [SUM_W-1:0]   sum_x_q, sum_y_q;
	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic                      all_valid_q;
	logic                      neg_x_q, neg_y_q;
	logic [SUM_W-1:0]          quot_x_q, quot_y_q;
	logic [REM_W-1:0]          rem_x_q, rem_y_q;
	logic                      stab_q;

	// Output register
	logic signed [COORD_W-1:0] mean_x_q, mean_y_q;
	logic [CNT_W-1:0]          held_out_q;
	logic                      stable_q;

	logic signed [COORD_W-1:0] ent_x, ent_y;
	logic                      ent_v;
	logic [SUM_W-1:0]          mag_x, mag_y;
	logic [REM_W-1:0]          trial_x, trial_y, divisor;
	logic [COORD_W:0]          spread_x, spread_y;
	logic                      stab_now;
	logic [SUM_W-1:0]          res_x, res_y;

	assign ent_v = rd_data_q[2*COORD_W];
	assign ent_x = rd_data_q[2*COORD_W-1:COORD_W];
	assign ent_y = rd_data_q[COORD_W-1:0];

	// Substitute the missing-point code
	assign wr_data = point_valid ? {1'b1, point_x, point_y}
		: {1'b0, COORD_W'(MISSING_CODE), COORD_W'(MISSING_CODE)};

	// Status back to the sequencer
	assign stat.scan_last = (CNT_W'(idx_q) == held_q - 1'b1);
	assign stat.div_last  = (div_cnt_q == '0);
	assign stat.out_free  = !out_full_q || out_ready;

	// Sign and magnitude of the sums
	assign mag_x = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
	assign mag_y = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);

	// One restoring-division bit per lane
	assign divisor = REM_W'(held_q);
	assign trial_x = {rem_x_q[REM_W-2:0], quot_x_q[SUM_W-1]};
	assign trial_y = {rem_y_q[REM_W-2:0], quot_y_q[SUM_W-1]};

	// Spread against tolerance
	assign spread_x = {max_x_q[COORD_W-1], max_x_q} - {min_x_q[COORD_W-1], min_x_q};
	assign spread_y = {max_y_q[COORD_W-1], max_y_q} - {min_y_q[COORD_W-1], min_y_q};
	assign stab_now = (held_q == CNT_W'(DEPTH)) && all_valid_q
		&& (CMP_W'(spread_x[COORD_W-1:0]) <= CMP_W'(tol_x_q))
		&& (CMP_W'(spread_y[COORD_W-1:0]) <= CMP_W'(tol_y_q));

	// Restore the sign of the quotients
	assign res_x = neg_x_q ? SUM_W'(-quot_x_q) : quot_x_q;
	assign res_y = neg_y_q ? SUM_W'(-quot_y_q) : quot_y_q;

	// Write and read the window memory
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mem_q[slot_q] <= wr_data;
		end
		if (ctrl.read) begin
			rd_data_q <= mem_q[idx_q];
		end
	end

	// Hold tolerances, window pointers and sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_x_q    <= TOL_W'(TOL_RESET);
			tol_y_q    <= TOL_W'(TOL_RESET);
			slot_q     <= '0;
			held_q     <= '0;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			first_q    <= 1'b0;
			div_cnt_q  <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_TOL_X) begin
				tol_x_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_TOL_Y) begin
				tol_y_q <= cfg_data;
			end
			pend_q <= ctrl.read;
			if (ctrl.start) begin
				slot_q  <= (slot_q == ADDR_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (held_q != CNT_W'(DEPTH)) begin
					held_q <= held_q + 1'b1;
				end
				idx_q   <= '0;
				first_q <= 1'b1;
			end else begin
				if (ctrl.read) begin
					idx_q <= idx_q + 1'b1;
				end
				if (ctrl.acc && pend_q) begin
					first_q <= 1'b0;
				end
			end
			if (ctrl.div_init) begin
				div_cnt_q <= DCNT_W'(SUM_W - 1);
			end else if (ctrl.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (ctrl.finish) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	// Accumulate, divide and load the output word
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			all_valid_q <= 1'b1;
		end else if (ctrl.acc && pend_q) begin
			sum_x_q <= sum_x_q + SUM_W'(ent_x);
			sum_y_q <= sum_y_q + SUM_W'(ent_y);
			if (!ent_v) begin
				all_valid_q <= 1'b0;
			end
			if (first_q || ent_x < min_x_q) min_x_q <= ent_x;
			if (first_q || ent_x > max_x_q) max_x_q <= ent_x;
			if (first_q || ent_y < min_y_q) min_y_q <= ent_y;
			if (first_q || ent_y > max_y_q) max_y_q <= ent_y;
		end
		if (ctrl.div_init) begin
			neg_x_q  <= sum_x_q[SUM_W-1];
			neg_y_q  <= sum_y_q[SUM_W-1];
			quot_x_q <= mag_x;
			quot_y_q <= mag_y;
			rem_x_q  <= '0;
			rem_y_q  <= '0;
			stab_q   <= stab_now;
		end else if (ctrl.div_step) begin
			if (trial_x >= divisor) begin
				rem_x_q  <= trial_x - divisor;
				quot_x_q <= {quot_x_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_x_q  <= trial_x;
				quot_x_q <= {quot_x_q[SUM_W-2:0], 1'b0};
			end
			if (trial_y >= divisor) begin
				rem_y_q  <= trial_y - divisor;
				quot_y_q <= {quot_y_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_y_q  <= trial_y;
				quot_y_q <= {quot_y_q[SUM_W-2:0], 1'b0};
			end
		end
		if (ctrl.finish) begin
			mean_x_q   <= COORD_W'(res_x);
			mean_y_q   <= COORD_W'(res_y);
			held_out_q <= held_q;
			stable_q   <= stab_q;
		end
	end

	assign mean_x       = mean_x_q;
	assign mean_y       = mean_y_q;
	assign samples_held = held_out_q;
	assign stable       = stable_q;
	assign out_valid    = out_full_q;

`ifndef ASSERT_OFF
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(DEPTH))
		else $error("held count above window depth");

	a_held_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> held_q != '0)
		else $error("window empty after a stored word");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.div_step |=> (rem_x_q < divisor) && (rem_y_q < divisor))
		else $error("divider remainder not below held count");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> !out_full_q || out_ready)
		else $error("output word overwritten before taken");
`endif

endmodule

// ===== rtl/core/point_window_average_stability.sv =====
// Channel | Direction | tdata (low bit up)                  | tuser
// s_*     | in        | point_x, point_y                    | point_valid
// m_*     | out       | mean_x, mean_y, samples_held        | stable
// cfg_*   | in        | cfg_index 0 x spread limit, 1 y spread limit (write only)
//
// Each word passes through the one-entry-a-cycle window scan on the memory read
// port and then through the one-bit-a-cycle restoring divider.
// s_tready is high only while the sequencer waits in its first step.
// A finished word waits in the output register while the next word is taken.
// arst_n clears window pointers, counts and the sequencer; no clearing pass.
module point_window_average_stability
	import pwas_pkg::*;
#(
	parameter int DEPTH   = DEPTH_DEF,
	parameter int COORD_W = COORD_W_DEF,
	localparam int CNT_W  = $clog2(DEPTH + 1),
	localparam int IN_W   = ((2 * COORD_W + 7) / 8) * 8,
	localparam int OUT_W  = ((2 * COORD_W + CNT_W + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // point_x, point_y
	input  logic                 s_tuser,   // point_valid
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // mean_x, mean_y, samples_held
	output logic                 m_tuser,   // stable
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOL_W-1:0]     cfg_data
);

	ctrl_t ctrl;
	stat_t stat;

	logic signed [COORD_W-1:0] mean_x, mean_y;
	logic [CNT_W-1:0]          samples_held;

	// Step through the control program
	pwas_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// Window, accumulators, divider and output register
	pwas_datapath #(
		.DEPTH   (DEPTH),
		.COORD_W (COORD_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.point_x      (s_tdata[COORD_W-1:0]),
		.point_y      (s_tdata[2*COORD_W-1:COORD_W]),
		.point_valid  (s_tuser),
		.mean_x       (mean_x),
		.mean_y       (mean_y),
		.samples_held (samples_held),
		.stable       (m_tuser),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready)
	);

	// Pack the result word, zero fill to bytes
	assign m_tdata = OUT_W'({samples_held, mean_y, mean_x});

endmodule

// ===== sim/point_window_average_stability_test.sv =====
module point_window_average_stability_test;
	import pwas_pkg::*;

	localparam int DEPTH           = DEPTH_DEF;
	localparam int IDLE_LIMIT      = 2000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_POINTS    = 300;

	typedef struct {
		logic signed [15:0] mean_x;
		logic signed [15:0] mean_y;
		logic [3:0]         held;
		logic               stable;
	} window_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // point_x, point_y
	logic        s_tuser = 1'b0; // point_valid
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // mean_x, mean_y, samples_held
	logic        m_tuser;        // stable
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TOL_X;
	logic [TOL_W-1:0]     cfg_data = '0;

	// window copy kept alongside the block
	logic signed [15:0] win_x [DEPTH];
	logic signed [15:0] win_y [DEPTH];
	logic               win_ok [DEPTH];
	int next_slot = 0;
	int held_cnt = 0;
	int tol_x = TOL_RESET;
	int tol_y = TOL_RESET;

	window_result_t pending_means [$];
	window_result_t want;

	int mismatches = 0;
	int points_sent = 0;
	int points_missing = 0;
	int results_checked = 0;
	int stable_seen = 0;
	int idle_cycles = 0;

	// sender and receiver pacing
	bit tx_eager = 1'b0;
	logic rx_eager = 1'b0;
	int rx_left = 0;
	int hold_req_cnt = 0;
	int hold_seen = 0;

	point_window_average_stability u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// mostly no gap, some short, a few long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// write a point into the window copy, return the mean, count and stable flag
	function automatic window_result_t track_point(input logic signed [15:0] px,
			input logic signed [15:0] py, input logic ok);
		window_result_t r;
		int sum_x, sum_y, lo_x, hi_x, lo_y, hi_y;
		bit all_ok;
		if (ok) begin
			win_x[next_slot] = px;
			win_y[next_slot] = py;
		end else begin
			win_x[next_slot] = 16'(MISSING_CODE);
			win_y[next_slot] = 16'(MISSING_CODE);
		end
		win_ok[next_slot] = ok;
		next_slot = (next_slot == DEPTH - 1) ? 0 : next_slot + 1;
		if (held_cnt < DEPTH)
			held_cnt++;
		sum_x = 0;
		sum_y = 0;
		all_ok = 1'b1;
		lo_x = win_x[0];
		hi_x = win_x[0];
		lo_y = win_y[0];
		hi_y = win_y[0];
		for (int k = 0; k < held_cnt; k++) begin
			sum_x += win_x[k];
			sum_y += win_y[k];
			if (win_x[k] < lo_x) lo_x = win_x[k];
			if (win_x[k] > hi_x) hi_x = win_x[k];
			if (win_y[k] < lo_y) lo_y = win_y[k];
			if (win_y[k] > hi_y) hi_y = win_y[k];
			if (!win_ok[k]) all_ok = 1'b0;
		end
		r.mean_x = 16'(sum_x / held_cnt);
		r.mean_y = 16'(sum_y / held_cnt);
		r.held = 4'(held_cnt);
		r.stable = (held_cnt == DEPTH) && all_ok && (hi_x - lo_x <= tol_x)
			&& (hi_y - lo_y <= tol_y);
		return r;
	endfunction

	// offer one point and wait for the block to take it
	task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
			input logic ok);
		int gap;
		gap = tx_eager ? 0 : idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		s_tuser <= ok;
		do @(posedge clk); while (!s_tready);
		pending_means.push_back(track_point(px, py, ok));
		points_sent++;
		if (!ok) points_missing++;
	endtask

	// stop offering and wait until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_means.size() != 0) @(posedge clk);
	endtask

	task automatic write_tolerance(input reg_idx_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= TOL_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TOL_X)
			tol_x = value;
		else
			tol_y = value;
		@(posedge clk);
	endtask

	// extremes of both axes while the window fills
	task automatic test_fill_window();
		repeat (DEPTH) send_point(16'sh7fff, -16'sh8000, 1'b1);
		send_point(-16'sh8000, 16'sh7fff, 1'b1);
		send_point(-16'sd1, -16'sd7, 1'b1);
		send_point(-16'sd2, 16'sd3, 1'b1);
		send_point(16'sd0, -16'sd1, 1'b1);
		drain_results();
	endtask

	// missing point stored as -1.0, blocks stable until overwritten
	task automatic test_missing_point();
		send_point(16'sh1234, -16'sh5678, 1'b0);
		repeat (DEPTH - 1) send_point(-16'sd16, -16'sd16, 1'b1);
		send_point(-16'sd16, -16'sd16, 1'b1);
		// spread right at the tolerance, then one past it
		send_point(16'sd0, -16'sd16, 1'b1);
		send_point(16'sd1, -16'sd16, 1'b1);
		drain_results();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_backpressure();
		hold_req_cnt <= hold_req_cnt + 1;
		tx_eager = 1'b1;
		repeat (24) send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			1'b1);
		tx_eager = 1'b0;
		drain_results();
	endtask

	// clustered runs around a random center, mixed with noise
	task automatic run_random_phase(input int tx, input int ty, input int count);
		int sent, run_len, jx, jy, cx, cy;
		bit noise, burst;
		write_tolerance(REG_TOL_X, tx);
		write_tolerance(REG_TOL_Y, ty);
		sent = 0;
		while (sent < count) begin
			noise = ($urandom_range(0, 99) < 20);
			burst = ($urandom_range(0, 99) < 10);
			tx_eager = burst;
			rx_eager <= burst;
			if (noise) begin
				run_len = $urandom_range(1, 12);
				repeat (run_len) send_point(16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)));
			end else begin
				run_len = $urandom_range(6, 24);
				jx = $urandom_range(0, tx + tx / 4 + 2);
				jy = $urandom_range(0, ty + ty / 4 + 2);
				if (jx > 65535) jx = 65535;
				if (jy > 65535) jy = 65535;
				cx = -32768 + $urandom_range(0, 65535 - jx);
				cy = -32768 + $urandom_range(0, 65535 - jy);
				repeat (run_len) send_point(16'(cx + $urandom_range(0, jx)),
					16'(cy + $urandom_range(0, jy)), ($urandom_range(0, 19) != 0));
			end
			sent += run_len;
		end
		tx_eager = 1'b0;
		rx_eager <= 1'b0;
		drain_results();
	endtask

	task automatic test_tolerance_phases();
		run_random_phase(0, 0, PHASE_POINTS);
		run_random_phase(32767, 32767, PHASE_POINTS);
		run_random_phase(0, 32767, PHASE_POINTS);
		run_random_phase(32767, 0, PHASE_POINTS);
		run_random_phase($urandom_range(0, 300), $urandom_range(0, 300), PHASE_POINTS);
		run_random_phase(48, 24, PHASE_POINTS);
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req_cnt != hold_seen) begin
			hold_seen <= hold_req_cnt;
			rx_left <= HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else if (rx_left != 0) begin
			rx_left <= rx_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!rx_eager)
				rx_left <= idle_gap();
		end
	end

	// compare each result word with the oldest expected mean
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected word mean_x %0d mean_y %0d held %0d stable %0d",
					$time, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
					m_tdata[35:32], m_tuser);
				mismatches++;
			end else begin
				want = pending_means.pop_front();
				results_checked++;
				if (m_tuser) stable_seen++;
				if (m_tdata[15:0] !== want.mean_x) begin
					$display("%0t: mean_x expected %0d got %0d", $time, want.mean_x,
						$signed(m_tdata[15:0]));
					mismatches++;
				end
				if (m_tdata[31:16] !== want.mean_y) begin
					$display("%0t: mean_y expected %0d got %0d", $time, want.mean_y,
						$signed(m_tdata[31:16]));
					mismatches++;
				end
				if (m_tdata[35:32] !== want.held) begin
					$display("%0t: samples_held expected %0d got %0d", $time, want.held,
						m_tdata[35:32]);
					mismatches++;
				end
				if (m_tuser !== want.stable) begin
					$display("%0t: stable expected %0d got %0d", $time, want.stable,
						m_tuser);
					mismatches++;
				end
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("point_window_average_stability_test: errors");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_window();
		test_missing_point();
		test_output_backpressure();
		test_tolerance_phases();
		repeat (64) @(posedge clk);
		$display("sent %0d points (%0d missing) over six tolerance settings",
			points_sent, points_missing);
		$display("checked %0d window results, %0d of them stable", results_checked,
			stable_seen);
		if (mismatches == 0 && pending_means.size() == 0)
			$display("point_window_average_stability_test: clean");
		else
			$display("point_window_average_stability_test: errors");
		$finish;
	end

endmodule

// ===== point_window_average_stability.f =====
rtl/core/pwas_pkg.sv
rtl/core/pwas_sequencer.sv
rtl/core/pwas_datapath.sv
rtl/core/point_window_average_stability.sv
sim/point_window_average_stability_test.sv
